// File: rtl/fvnh_pkg.sv
// Shared types, constants and arithmetic helpers for the fractal value-noise height core.
package fvnh_pkg;

    localparam int OCT_N       = 5;
    localparam int GRID_N      = 16;
    localparam int PERIOD_LOG2 = 13;
    localparam int NS          = 11;

    // Pipeline stage indices.
    localparam int ST_IN     = 0;
    localparam int ST_SPLIT  = 1;
    localparam int ST_KEY    = 2;
    localparam int ST_SQ     = 3;
    localparam int ST_POLY   = 4;
    localparam int ST_NOISE  = 5;
    localparam int ST_SMOOTH = 6;
    localparam int ST_BLENDX = 7;
    localparam int ST_OCT    = 8;
    localparam int ST_SUM    = 9;
    localparam int ST_OUT    = 10;

    typedef logic [30:0]        hword_t;
    typedef logic signed [31:0] noise_t;
    typedef logic signed [35:0] smooth_t;
    typedef logic [15:0]        wgt_t;
    typedef logic [15:0]        frac_t;
    typedef logic [NS-1:0]      stage_en_t;

    typedef struct packed {
        hword_t lat;
        frac_t  fq;
    } split_t;

    typedef enum logic [1:0] {
        REG_COEF_A = 2'd0,
        REG_COEF_B = 2'd1,
        REG_COEF_C = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    function automatic logic [15:0] cos_tab(input logic [4:0] k);
        logic [15:0] v;
        case (k)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd630;
            5'd2:    v = 16'd2494;
            5'd3:    v = 16'd5522;
            5'd4:    v = 16'd9598;
            5'd5:    v = 16'd14563;
            5'd6:    v = 16'd20228;
            5'd7:    v = 16'd26375;
            5'd8:    v = 16'd32768;
            5'd9:    v = 16'd39161;
            5'd10:   v = 16'd45308;
            5'd11:   v = 16'd50973;
            5'd12:   v = 16'd55938;
            5'd13:   v = 16'd60014;
            5'd14:   v = 16'd63042;
            5'd15:   v = 16'd64906;
            default: v = 16'd65535;
        endcase
        return v;
    endfunction

    // Cosine weight in Q16: table value plus a linear step on the low 12 fraction bits.
    // The last entry is never reached as a base, and the interpolated weight stays below 65536.
    function automatic wgt_t cos_weight(input frac_t fq);
        logic [4:0]  k;
        logic [15:0] lo_v;
        logic [15:0] hi_v;
        logic [12:0] d;
        logic [24:0] p;
        k    = {1'b0, fq[15:12]};
        lo_v = cos_tab(k);
        hi_v = (k == 5'd15) ? 16'd65535 : cos_tab(k + 5'd1);
        d    = 13'(hi_v - lo_v);
        if (k == 5'd15)
        begin
            d = 13'd630;
        end
        p    = 25'(d) * 25'(fq[11:0]);
        return lo_v + 16'(p[24:12]);
    endfunction

    // Integer part truncates toward zero; the fraction is the magnitude of the remainder.
    function automatic split_t split_axis(input logic signed [23:0] pos, input logic [2:0] oct);
        logic signed [31:0] num;
        logic [31:0]        mag;
        logic [31:0]        q;
        split_t             r;
        num = 32'(pos) <<< oct;
        mag = num[31] ? 32'(-num) : 32'(num);
        q   = mag >> PERIOD_LOG2;
        if (num[31])
        begin
            q = 32'(-q);
        end
        r.lat = q[30:0];
        r.fq  = frac_t'(mag[PERIOD_LOG2-1:0]) << (16 - PERIOD_LOG2);
        return r;
    endfunction

    // (a*(1-w) + b*w) with floor rounding back to the operand scale.
    function automatic smooth_t blend(input smooth_t a, input smooth_t b, input wgt_t w);
        logic signed [17:0] wa;
        logic signed [17:0] wb;
        logic signed [54:0] pa;
        logic signed [54:0] pb;
        logic signed [54:0] s;
        wb = signed'({2'b00, w});
        wa = 18'sd65536 - wb;
        pa = 55'(a) * 55'(wa);
        pb = 55'(b) * 55'(wb);
        s  = pa + pb;
        return smooth_t'(s[51:16]);
    endfunction

endpackage

// File: rtl/fvnh_front.sv
// Lattice split, cosine weights and hash keys for every octave.
module fvnh_front import fvnh_pkg::*;
(
    input  logic               clk,
    input  stage_en_t          en,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    output hword_t             key [OCT_N][GRID_N],
    output wgt_t               wx [OCT_N],
    output wgt_t               wy [OCT_N]
);

    split_t sx_reg [OCT_N];
    split_t sy_reg [OCT_N];
    hword_t key_reg [OCT_N][GRID_N];
    wgt_t   wx_reg [OCT_N];
    wgt_t   wy_reg [OCT_N];

    genvar o;
    generate
        for (o = 0; o < OCT_N; o++)
        begin : g_oct
            always_ff @(posedge clk)
            begin
                if (en[ST_SPLIT])
                begin
                    sx_reg[o] <= split_axis(pos_x, 3'(o));
                    sy_reg[o] <= split_axis(pos_y, 3'(o));
                end
            end

            // Keys for the 4x4 neighborhood from lattice-1 to lattice+2 on each axis.
            always_ff @(posedge clk)
            begin
                hword_t lx;
                hword_t ly;
                hword_t n0;
                if (en[ST_KEY])
                begin
                    for (int gy = 0; gy < 4; gy++)
                    begin
                        for (int gx = 0; gx < 4; gx++)
                        begin
                            lx = sx_reg[o].lat + 31'(gx - 1);
                            ly = sy_reg[o].lat + 31'(gy - 1);
                            n0 = lx + 31'(ly * 31'd57);
                            key_reg[o][gy*4 + gx] <= n0 ^ (n0 << 13);
                        end
                    end
                    wx_reg[o] <= cos_weight(sx_reg[o].fq);
                    wy_reg[o] <= cos_weight(sy_reg[o].fq);
                end
            end

            assign key[o] = key_reg[o];
            assign wx[o]  = wx_reg[o];
            assign wy[o]  = wy_reg[o];
        end
    endgenerate

endmodule

// File: rtl/fvnh_hash.sv
// One lattice hash lane: key to noise value over three multiply stages.
module fvnh_hash import fvnh_pkg::*;
(
    input  logic      clk,
    input  stage_en_t en,
    input  hword_t    key,
    input  logic [7:0] coef_a,
    input  logic [7:0] coef_b,
    input  logic [7:0] coef_c,
    output noise_t    noise
);

    hword_t sq_reg;
    hword_t n1_reg;
    hword_t poly_reg;
    hword_t n2_reg;
    noise_t noise_reg;
    hword_t h;

    // Only the low 31 bits survive the final mask, so all hash arithmetic runs modulo 2^31.
    always_comb
    begin
        h = 31'(n2_reg * poly_reg) + 31'(coef_c);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SQ])
        begin
            sq_reg <= 31'(key * key);
            n1_reg <= key;
        end
        if (en[ST_POLY])
        begin
            poly_reg <= 31'(sq_reg * 31'(coef_a)) + 31'(coef_b);
            n2_reg   <= n1_reg;
        end
        if (en[ST_NOISE])
        begin
            noise_reg <= 32'sh4000_0000 - signed'({1'b0, h});
        end
    end

    assign noise = noise_reg;

endmodule

// File: rtl/fvnh_interp.sv
// Smoothing of the 4x4 noise grid and cosine blending to one octave value.
module fvnh_interp import fvnh_pkg::*;
(
    input  logic      clk,
    input  stage_en_t en,
    input  noise_t    grid [GRID_N],
    input  wgt_t      wx,
    input  wgt_t      wy,
    output smooth_t   value
);

    wgt_t    wx_pipe_reg [4];
    wgt_t    wy_pipe_reg [5];
    smooth_t sm_reg [4];
    smooth_t i1_reg;
    smooth_t i2_reg;
    smooth_t value_reg;
    smooth_t sm [4];

    // Corners once, sides twice, center four times around each of the four inner points.
    always_comb
    begin
        smooth_t corners;
        smooth_t sides;
        int      c;
        for (int p = 0; p < 4; p++)
        begin
            c = ((p / 2) + 1) * 4 + (p % 2) + 1;
            corners = 36'(grid[c-5]) + 36'(grid[c-3]) + 36'(grid[c+3]) + 36'(grid[c+5]);
            sides   = 36'(grid[c-4]) + 36'(grid[c-1]) + 36'(grid[c+1]) + 36'(grid[c+4]);
            sm[p]   = corners + (sides <<< 1) + (36'(grid[c]) <<< 2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SQ])
        begin
            wx_pipe_reg[0] <= wx;
            wy_pipe_reg[0] <= wy;
        end
        for (int s = 1; s < 4; s++)
        begin
            if (en[ST_SQ + s])
            begin
                wx_pipe_reg[s] <= wx_pipe_reg[s-1];
            end
        end
        for (int s = 1; s < 5; s++)
        begin
            if (en[ST_SQ + s])
            begin
                wy_pipe_reg[s] <= wy_pipe_reg[s-1];
            end
        end
        if (en[ST_SMOOTH])
        begin
            for (int p = 0; p < 4; p++)
            begin
                sm_reg[p] <= sm[p];
            end
        end
        if (en[ST_BLENDX])
        begin
            i1_reg <= blend(sm_reg[0], sm_reg[1], wx_pipe_reg[3]);
            i2_reg <= blend(sm_reg[2], sm_reg[3], wx_pipe_reg[3]);
        end
        if (en[ST_OCT])
        begin
            value_reg <= blend(i1_reg, i2_reg, wy_pipe_reg[4]);
        end
    end

    assign value = value_reg;

endmodule

// File: rtl/fractal_value_noise_height_core.sv
// Top level of the fractal value-noise terrain height core.
// This core turns a fixed-point 2D coordinate (13 fraction bits) into a terrain height in
// Q14, the saturated sum of five octaves of smoothed, cosine-interpolated lattice noise.
// It is an 11-stage pipeline: a new item can be taken every cycle while height_stall does
// not hold the output back, so the sustained rate is then one item per cycle. The depth
// is set by the hash lanes, whose three chained 31-bit multiplies each get a stage of
// their own, followed by smoothing, two blend stages and the octave sum. Each stage keeps
// its own valid bit and moves whenever it is empty or the stage after it moves, so
// bubbles are squeezed out and the input keeps being accepted while a finished height
// waits for the downstream side, as long as an empty stage is left. The three hash
// coefficients sit on a small APB-style port at byte addresses 0, 4 and 8; they should
// only be changed while no item is in flight.
module fractal_value_noise_height_core import fvnh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               pos_valid,
    output logic               pos_stall,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    output logic               height_valid,
    input  logic               height_stall,
    output logic signed [15:0] height
);

    logic [7:0]         coef_a_reg;
    logic [7:0]         coef_b_reg;
    logic [7:0]         coef_c_reg;
    logic [NS-1:0]      valid_reg;
    stage_en_t          en;
    logic signed [23:0] pos_x_reg;
    logic signed [23:0] pos_y_reg;
    logic signed [47:0] sum_reg;
    logic signed [47:0] sum_next;
    logic signed [15:0] height_reg;
    logic signed [15:0] height_next;
    logic signed [47:0] rounded;
    reg_idx_t           reg_sel;

    hword_t  key [OCT_N][GRID_N];
    wgt_t    wx [OCT_N];
    wgt_t    wy [OCT_N];
    noise_t  noise [OCT_N][GRID_N];
    smooth_t oct_val [OCT_N];

    // Configuration port. Writes land in the access phase; addresses 12 to 15 are ignored.
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= 8'd151;
            coef_b_reg <= 8'd160;
            coef_c_reg <= 8'd137;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_sel)
                REG_COEF_A: coef_a_reg <= pwdata[7:0];
                REG_COEF_B: coef_b_reg <= pwdata[7:0];
                REG_COEF_C: coef_c_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_COEF_A: prdata = {24'd0, coef_a_reg};
            REG_COEF_B: prdata = {24'd0, coef_b_reg};
            REG_COEF_C: prdata = {24'd0, coef_c_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // A stage loads when it is empty or when the stage after it is moving on.
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || !height_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign pos_stall = !en[ST_IN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[ST_IN])
            begin
                valid_reg[ST_IN] <= pos_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
        end
    end

    fvnh_front u_front
    (
        .clk   (clk),
        .en    (en),
        .pos_x (pos_x_reg),
        .pos_y (pos_y_reg),
        .key   (key),
        .wx    (wx),
        .wy    (wy)
    );

    genvar o;
    genvar g;
    generate
        for (o = 0; o < OCT_N; o++)
        begin : g_oct
            for (g = 0; g < GRID_N; g++)
            begin : g_lane
                fvnh_hash u_hash
                (
                    .clk    (clk),
                    .en     (en),
                    .key    (key[o][g]),
                    .coef_a (coef_a_reg),
                    .coef_b (coef_b_reg),
                    .coef_c (coef_c_reg),
                    .noise  (noise[o][g])
                );
            end

            fvnh_interp u_interp
            (
                .clk   (clk),
                .en    (en),
                .grid  (noise[o]),
                .wx    (wx[o]),
                .wy    (wy[o]),
                .value (oct_val[o])
            );
        end
    endgenerate

    // Octave i carries weight 2^(7-i) in the exact Q41 sum.
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < OCT_N; i++)
        begin
            sum_next = sum_next + (48'(oct_val[i]) <<< (7 - i));
        end
    end

    // Round half up to Q14, then clamp to the 16-bit output range.
    always_comb
    begin
        rounded = (sum_reg + 48'sh400_0000) >>> 27;
        if (rounded > 48'sd32767)
        begin
            height_next = 16'sh7FFF;
        end
        else if (rounded < -48'sd32768)
        begin
            height_next = 16'sh8000;
        end
        else
        begin
            height_next = 16'(rounded);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            sum_reg <= sum_next;
        end
        if (en[ST_OUT])
        begin
            height_reg <= height_next;
        end
    end

    assign height_valid = valid_reg[NS-1];
    assign height       = height_reg;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the fractal value-noise terrain height core.
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
    } coord_t;

    // Clock, reset and every block input start at known values.
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [3:0]         paddr        = 4'd0;
    logic [31:0]        pwdata       = 32'd0;
    logic [31:0]        prdata;
    logic               pready;
    logic               pos_valid    = 1'b0;
    logic               pos_stall;
    logic signed [23:0] pos_x        = 24'sd0;
    logic signed [23:0] pos_y        = 24'sd0;
    logic               height_valid;
    logic               height_stall = 1'b0;
    logic signed [15:0] height;

    // Our copy of the three hash coefficients, kept in step with every register write.
    bit [31:0] coef_a = 32'd151;
    bit [31:0] coef_b = 32'd160;
    bit [31:0] coef_c = 32'd137;

    coord_t             coords_to_send[$];
    logic signed [15:0] heights_due[$];
    int                 mismatches = 0;
    bit                 steady_send = 1'b0;

    fractal_value_noise_height_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pos_valid    (pos_valid),
        .pos_stall    (pos_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .height_valid (height_valid),
        .height_stall (height_stall),
        .height       (height)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Height predictor. All hash arithmetic wraps at 32 bits; the rest is
    // carried exactly in 64-bit signed integers.
    // ------------------------------------------------------------------

    // Lattice value in Q30: 2^30 minus a 31-bit hash of the point.
    function automatic longint lattice_value(bit [31:0] lx, bit [31:0] ly);
        bit [31:0] n;
        bit [31:0] h;
        n = lx + ly * 32'd57;
        n = (n << 13) ^ n;
        h = (n * (n * n * coef_a + coef_b) + coef_c) & 32'h7FFF_FFFF;
        return (64'sd1 <<< 30) - longint'(h);
    endfunction

    // 3x3 smoothing with corner, side and center weights 1, 2 and 4 (Q34).
    function automatic longint smoothed_value(bit [31:0] lx, bit [31:0] ly);
        longint corners;
        longint sides;
        corners = lattice_value(lx - 1, ly - 1) + lattice_value(lx + 1, ly - 1)
                + lattice_value(lx - 1, ly + 1) + lattice_value(lx + 1, ly + 1);
        sides   = lattice_value(lx - 1, ly) + lattice_value(lx + 1, ly)
                + lattice_value(lx, ly - 1) + lattice_value(lx, ly + 1);
        return corners + 2 * sides + 4 * lattice_value(lx, ly);
    endfunction

    // Cosine weight in Q16 from a 17-point table, linear between points.
    function automatic longint cos_wt(longint fq);
        longint tab[17] = '{0, 630, 2494, 5522, 9598, 14563, 20228, 26375, 32768,
                            39161, 45308, 50973, 55938, 60014, 63042, 64906, 65536};
        longint k;
        longint lo;
        k  = (fq >>> 12) & 15;
        lo = fq & 12'hFFF;
        return tab[k] + (((tab[k + 1] - tab[k]) * lo) >>> 12);
    endfunction

    function automatic longint mix(longint a, longint b, longint w);
        return (a * (65536 - w) + b * w) >>> 16;
    endfunction

    // Lattice index truncates toward zero; the weight uses the remainder's magnitude.
    function automatic void coord_split(logic signed [23:0] pos, int oct,
                                        output bit [31:0] lat, output longint w);
        longint num;
        longint q;
        longint r;
        num = longint'(pos) * (64'sd1 <<< oct);
        q   = num / 8192;
        r   = num - q * 8192;
        if (r < 0)
        begin
            r = -r;
        end
        lat = q[31:0];
        w   = cos_wt((r << 16) / 8192);
    endfunction

    function automatic logic signed [15:0] terrain_height(coord_t c);
        longint    total;
        longint    wx;
        longint    wy;
        longint    row0;
        longint    row1;
        longint    h;
        bit [31:0] lx;
        bit [31:0] ly;
        total = 0;
        for (int oct = 0; oct < 5; oct++)
        begin
            coord_split(c.x, oct, lx, wx);
            coord_split(c.y, oct, ly, wy);
            row0 = mix(smoothed_value(lx, ly), smoothed_value(lx + 1, ly), wx);
            row1 = mix(smoothed_value(lx, ly + 1), smoothed_value(lx + 1, ly + 1), wx);
            total += mix(row0, row1, wy) * (64'sd1 <<< (7 - oct));
        end
        h = (total + (64'sd1 <<< 26)) >>> 27;
        if (h > 32767)
        begin
            h = 32767;
        end
        if (h < -32768)
        begin
            h = -32768;
        end
        return h[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Coordinate driver. It sends in bursts with random gaps between them,
    // unless a phase asks for back-to-back items. A stalled item is held
    // unchanged. The expected height is worked out when the item is taken.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid  <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!(pos_valid && pos_stall))
        begin
            if (pos_valid)
            begin
                heights_due.push_back(terrain_height(coords_to_send[0]));
                void'(coords_to_send.pop_front());
            end
            if (gap_left > 0 && !steady_send)
            begin
                gap_left  <= gap_left - 1;
                pos_valid <= 1'b0;
            end
            else if (coords_to_send.size() > 0)
            begin
                pos_valid <= 1'b1;
                pos_x     <= coords_to_send[0].x;
                pos_y     <= coords_to_send[0].y;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                pos_valid <= 1'b0;
            end
        end
    end

    // Height receiver. It stalls on a rotating 16-bit pattern that is redrawn each
    // time it wraps; about a quarter of the patterns are all clear.
    logic [15:0] stall_pattern = 16'h0;
    int          stall_phase   = 0;

    always @(posedge clk)
    begin
        height_stall <= stall_pattern[stall_phase];
        if (stall_phase == 15)
        begin
            stall_phase   <= 0;
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
        end
        else
        begin
            stall_phase <= stall_phase + 1;
        end
    end

    // Height checker: each accepted height is compared with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && height_valid && !height_stall)
        begin
            if (heights_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("height %0d arrived with no item outstanding", height);
                end
            end
            else
            begin
                if (height !== heights_due[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("height mismatch: expected %0d, got %0d",
                                 heights_due[0], height);
                    end
                end
                void'(heights_due.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Register access and phase control.
    // ------------------------------------------------------------------

    // One APB write: a setup cycle, then an access cycle that completes at the
    // next edge. Only the low 8 bits are kept, and the unused index is ignored.
    task automatic write_coef(fvnh_pkg::reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            fvnh_pkg::REG_COEF_A: coef_a = {24'd0, value[7:0]};
            fvnh_pkg::REG_COEF_B: coef_b = {24'd0, value[7:0]};
            fvnh_pkg::REG_COEF_C: coef_c = {24'd0, value[7:0]};
            default: ;
        endcase
    endtask

    // Waits until every item is sent and checked, then lets the pipeline drain.
    task automatic wait_idle();
        while (coords_to_send.size() > 0 || heights_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    // Random coordinate: full range, near the origin, or close to a lattice line.
    function automatic coord_t random_coord();
        coord_t c;
        case ($urandom_range(0, 2))
            0:
            begin
                c.x = 24'($urandom);
                c.y = 24'($urandom);
            end
            1:
            begin
                c.x = 24'($signed($urandom_range(0, 65535)) - 32768);
                c.y = 24'($signed($urandom_range(0, 65535)) - 32768);
            end
            default:
            begin
                c.x = 24'(($signed($urandom_range(0, 2047)) - 1024) * 8192
                          + $signed($urandom_range(0, 6)) - 3);
                c.y = 24'(($signed($urandom_range(0, 2047)) - 1024) * 8192
                          + $signed($urandom_range(0, 6)) - 3);
            end
        endcase
        return c;
    endfunction

    task automatic random_phase(int count);
        repeat (count) coords_to_send.push_back(random_coord());
        wait_idle();
    endtask

    initial
    begin
        coord_t c;
        logic signed [23:0] corner_vals[8] = '{24'sh000000, 24'sh7FFFFF, -24'sh800000,
                                               24'sh000001, -24'sh000001, 24'sh002000,
                                               -24'sh002000, 24'sh001FFF};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under reset coefficients: field extremes, negative
        // coordinates with truncation toward zero, and lattice boundaries.
        for (int i = 0; i < 8; i++)
        begin
            c.x = corner_vals[i];
            c.y = corner_vals[(i * 3 + 1) % 8];
            coords_to_send.push_back(c);
            c.x = corner_vals[i];
            c.y = corner_vals[i];
            coords_to_send.push_back(c);
        end
        c.x = 24'sh7FFFFF;
        c.y = -24'sh800000;
        coords_to_send.push_back(c);
        c.x = -24'sh800000;
        c.y = 24'sh7FFFFF;
        coords_to_send.push_back(c);
        wait_idle();

        // All coefficients zero, with a write to the unused index that must not land.
        write_coef(fvnh_pkg::REG_COEF_A, 32'hFFFF_FF00);
        write_coef(fvnh_pkg::REG_COEF_B, 32'h0000_0000);
        write_coef(fvnh_pkg::REG_COEF_C, 32'h1234_5600);
        write_coef(fvnh_pkg::REG_NONE, 32'hFFFF_FFFF);
        random_phase(100);

        // All coefficients at their maximum, sent back to back.
        steady_send = 1'b1;
        write_coef(fvnh_pkg::REG_COEF_A, 32'hABCD_EFFF);
        write_coef(fvnh_pkg::REG_COEF_B, 32'h0000_00FF);
        write_coef(fvnh_pkg::REG_COEF_C, 32'hFFFF_FFFF);
        random_phase(100);

        // Random coefficients, with every third phase sent steadily and the others bursty.
        for (int p = 0; p < 6; p++)
        begin
            steady_send = (p % 3 == 2);
            write_coef(fvnh_pkg::REG_COEF_A, $urandom);
            write_coef(fvnh_pkg::REG_COEF_B, $urandom);
            write_coef(fvnh_pkg::REG_COEF_C, $urandom);
            if ($urandom_range(0, 1) == 1)
            begin
                write_coef(fvnh_pkg::REG_NONE, $urandom);
            end
            random_phase(190);
        end

        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
